FILE: hdl/tse_pkg.sv
// Shared types and constants for the trajectory segment evaluator.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tse_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int MAX_JOINTS_DEF   = 8;
  // Results carry a 3-bit joint number, so at most eight joints per query
  localparam int JOINT_CAP        = 8;
  localparam logic [3:0] JOINT_COUNT_RST = 4'd8;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_EVAL   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_CHK_C,
    S_CHK_N,
    S_SRCH,
    S_DT,
    S_SQ,
    S_JLOAD,
    S_JWAIT,
    S_JPUSH
  } state_t;

  typedef struct packed {
    logic [31:0] t_start;
    logic [31:0] t_end;
  } seg_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
  } coef_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               sat;
  } eval_res_t;

  typedef struct packed {
    logic [2:0]         joint;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
    logic [5:0]         seg;
    status_t            status;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/tse_seg_mem.sv
// Segment time table: start and end time per segment, one write and one read port.
// Depends on tse_pkg for the seg_t entry type.
`timescale 1ns / 1ps
`default_nettype none

module tse_seg_mem #(
  parameter int DEPTH = tse_pkg::MAX_SEGMENTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  tse_pkg::seg_t wdata,
  input  logic [AW-1:0] raddr,
  output tse_pkg::seg_t rdata
);

  tse_pkg::seg_t mem [DEPTH];
  tse_pkg::seg_t rdata_r;

  // Write on enable, read registered every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/tse_coef_mem.sv
// Joint coefficient table: position, velocity and acceleration per segment and joint.
// Depends on tse_pkg for the coef_t entry type.
`timescale 1ns / 1ps
`default_nettype none

module tse_coef_mem #(
  parameter int DEPTH = tse_pkg::MAX_SEGMENTS_DEF * tse_pkg::MAX_JOINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  tse_pkg::coef_t wdata,
  input  logic [AW-1:0]  raddr,
  output tse_pkg::coef_t rdata
);

  tse_pkg::coef_t mem [DEPTH];
  tse_pkg::coef_t rdata_r;

  // Write on enable, read registered every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/tse_eval.sv
// Per-joint evaluation datapath: clamped Q16.16 products, exact sums, saturation.
// Depends on tse_pkg for coef_t and eval_res_t.
`timescale 1ns / 1ps
`default_nettype none

module tse_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [32:0]  dt,
  input  logic [46:0]         h,
  input  tse_pkg::coef_t      coef,
  output logic                done,
  output tse_pkg::eval_res_t  res
);

  localparam logic [78:0] MAG_LIM = 79'd1 << 62;
  localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

  logic [4:0]         stg_r;
  logic [31:0]        adt_r, mv_r, ma_r;
  logic               dneg_r, vneg_r, aneg_r;
  logic [46:0]        h_r;
  logic signed [31:0] q0_r, v_r;
  logic [63:0]        p_dv_r, p_da_r;
  logic [55:0]        p_la_r;
  logic [54:0]        p_ha_r;
  logic signed [47:0] t_dv_r, t_da_r, t_ha_r;
  tse_pkg::eval_res_t res_r;

  logic [32:0]        ndt;
  logic [31:0]        nv, na;
  logic [78:0]        p_hfull;
  logic signed [49:0] psum, vsum;

  // Round toward minus infinity after clamping the magnitude
  function automatic logic signed [47:0] qterm(input logic [78:0] p, input logic neg);
    logic [62:0] m;
    logic [46:0] mag;
    m = (p > MAG_LIM) ? MAG_LIM[62:0] : p[62:0];
    if (neg) begin
      mag = 47'((64'(m) + 64'hFFFF) >> 16);
    end else begin
      mag = 47'(m >> 16);
    end
    qterm = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Magnitudes of the operands
  always_comb begin
    ndt = -dt;
    nv  = -coef.vel;
    na  = -coef.acc;
  end

  // Stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r <= {stg_r[3:0], start};
    end
  end

  // Latch operands as sign and magnitude
  always_ff @(posedge clk) begin
    if (start) begin
      dneg_r <= dt[32];
      adt_r  <= dt[32] ? ndt[31:0] : dt[31:0];
      vneg_r <= coef.vel[31];
      mv_r   <= coef.vel[31] ? nv : coef.vel;
      aneg_r <= coef.acc[31];
      ma_r   <= coef.acc[31] ? na : coef.acc;
      h_r    <= h;
      q0_r   <= coef.pos;
      v_r    <= coef.vel;
    end
  end

  // Multiply: dt*v, dt*a and low half of h*a, then high half of h*a
  always_ff @(posedge clk) begin
    if (stg_r[0]) begin
      p_dv_r <= 64'(adt_r) * 64'(mv_r);
      p_da_r <= 64'(adt_r) * 64'(ma_r);
      p_la_r <= 56'(h_r[23:0]) * 56'(ma_r);
    end
    if (stg_r[1]) begin
      p_ha_r <= 55'(h_r[46:24]) * 55'(ma_r);
    end
  end

  assign p_hfull = {p_ha_r, 24'b0} + 79'(p_la_r);

  // Clamp, scale and sign the three terms
  always_ff @(posedge clk) begin
    if (stg_r[2]) begin
      t_dv_r <= qterm(79'(p_dv_r), dneg_r ^ vneg_r);
      t_da_r <= qterm(79'(p_da_r), dneg_r ^ aneg_r);
      t_ha_r <= qterm(p_hfull, aneg_r);
    end
  end

  // Sum exactly and saturate
  always_comb begin
    psum = {{18{q0_r[31]}}, q0_r} + {{2{t_dv_r[47]}}, t_dv_r} + {{2{t_ha_r[47]}}, t_ha_r};
    vsum = {{18{v_r[31]}}, v_r} + {{2{t_da_r[47]}}, t_da_r};
  end

  always_ff @(posedge clk) begin
    if (stg_r[3]) begin
      if (psum > SAT_HI) begin
        res_r.pos <= 32'sh7FFF_FFFF;
      end else if (psum < SAT_LO) begin
        res_r.pos <= 32'sh8000_0000;
      end else begin
        res_r.pos <= psum[31:0];
      end
      if (vsum > SAT_HI) begin
        res_r.vel <= 32'sh7FFF_FFFF;
      end else if (vsum < SAT_LO) begin
        res_r.vel <= 32'sh8000_0000;
      end else begin
        res_r.vel <= vsum[31:0];
      end
      res_r.sat <= (psum > SAT_HI) || (psum < SAT_LO) || (vsum > SAT_HI) || (vsum < SAT_LO);
    end
  end

  assign done = stg_r[4];
  assign res  = res_r;

endmodule

`default_nettype wire

FILE: hdl/trajectory_segment_evaluator.sv
// Trajectory segment evaluator: segment table, cached lookup, per-joint evaluation.
// Append, write, clear and evaluate on an empty table: result held in the response state, then registered out.
// Evaluate: cached lookup of the cached segment and the one after it, or else linear search
// (one segment end read per cycle), then dt and dt*dt, then per joint load, evaluate and push.
// One item at a time: a new request is taken only in the idle state.
// Reset (synchronous, rst_n low): table empty, cache invalid, joint_count 8; tables not cleared.
`timescale 1ns / 1ps
`default_nettype none

module trajectory_segment_evaluator #(
  parameter int MAX_SEGMENTS = tse_pkg::MAX_SEGMENTS_DEF,
  parameter int MAX_JOINTS   = tse_pkg::MAX_JOINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [5:0]         in_seg_index,
  input  logic [2:0]         in_joint_index,
  input  logic [31:0]        in_start_time,
  input  logic [31:0]        in_end_time,
  input  logic [31:0]        in_query_time,
  input  logic signed [31:0] in_start_pos,
  input  logic signed [31:0] in_start_vel,
  input  logic signed [31:0] in_accel_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_joint_out,
  output logic signed [31:0] out_position,
  output logic signed [31:0] out_velocity,
  output logic signed [31:0] out_acceleration,
  output logic [5:0]         out_segment_used,
  output logic [1:0]         out_status,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata
);

  localparam int SEGW   = $clog2(MAX_SEGMENTS);
  localparam int CNTW   = $clog2(MAX_SEGMENTS + 1);
  localparam int CDEPTH = MAX_SEGMENTS * MAX_JOINTS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int NCAP   = (MAX_JOINTS < tse_pkg::JOINT_CAP) ? MAX_JOINTS : tse_pkg::JOINT_CAP;

  tse_pkg::state_t    state_r, state_nxt;
  logic [CNTW-1:0]    count_r;
  logic [SEGW-1:0]    cached_r;
  logic               cvalid_r;
  logic [3:0]         jc_r;
  logic [31:0]        qtime_r;
  logic [SEGW-1:0]    srch_r;
  logic [SEGW-1:0]    seg_r;
  logic [31:0]        start_r;
  logic signed [32:0] dt_r;
  logic [46:0]        h_r;
  logic [2:0]         j_r;
  logic [3:0]         n_r;
  tse_pkg::res_t      res_r, res_nxt;
  tse_pkg::res_t      out_r;
  logic               out_valid_r;

  logic               accept, out_free, out_load;
  logic               full, wr_bad, seg_we, coef_we;
  logic [SEGW-1:0]    c0;
  logic [SEGW-1:0]    seg_raddr;
  logic [CAW-1:0]     coef_waddr, coef_raddr;
  tse_pkg::seg_t      sd;
  tse_pkg::coef_t     cd;
  logic               holds, nxt_ok, after_end, srch_go, ev_start, ev_done, jlast;
  tse_pkg::eval_res_t ev;
  logic [31:0]        adt;
  logic [32:0]        ndt;
  logic [63:0]        sq;
  logic [3:0]         n_eff;
  tse_pkg::res_t      jres;

  // Handshake and table conditions
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == tse_pkg::S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign full     = (count_r >= CNTW'(MAX_SEGMENTS));
  assign wr_bad   = ({26'b0, in_seg_index} >= 32'(MAX_SEGMENTS)) ||
                    ({29'b0, in_joint_index} >= 32'(MAX_JOINTS));
  assign seg_we   = accept && (in_req_type == tse_pkg::REQ_APPEND) && !full;
  assign coef_we  = accept && (in_req_type == tse_pkg::REQ_WRITE) && !wr_bad;
  assign coef_waddr = CAW'(32'(in_seg_index) * 32'(MAX_JOINTS) + 32'(in_joint_index));

  // Cache entry to try first
  assign c0 = (!cvalid_r || (CNTW'(cached_r) >= count_r)) ? '0 : cached_r;

  // Segment tests on the entry just read
  assign holds     = (qtime_r >= sd.t_start) && (qtime_r <= sd.t_end);
  assign after_end = (qtime_r > sd.t_end);
  assign nxt_ok    = ((CNTW'(srch_r) + CNTW'(1)) < count_r);
  assign srch_go   = nxt_ok && after_end;

  // Joint count clamp
  always_comb begin
    if (jc_r == 4'd0) begin
      n_eff = 4'd1;
    end else if (32'(jc_r) > NCAP) begin
      n_eff = 4'(NCAP);
    end else begin
      n_eff = jc_r;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tse_pkg::S_IDLE: begin
        if (accept) begin
          if ((in_req_type == tse_pkg::REQ_EVAL) && (count_r != '0)) begin
            state_nxt = tse_pkg::S_CHK_C;
          end else begin
            state_nxt = tse_pkg::S_RESP;
          end
        end
      end
      tse_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = tse_pkg::S_IDLE;
        end
      end
      tse_pkg::S_CHK_C: begin
        priority if (holds) begin
          state_nxt = tse_pkg::S_DT;
        end else if (nxt_ok) begin
          state_nxt = tse_pkg::S_CHK_N;
        end else if (after_end) begin
          state_nxt = tse_pkg::S_DT;
        end else begin
          state_nxt = tse_pkg::S_SRCH;
        end
      end
      tse_pkg::S_CHK_N: begin
        state_nxt = holds ? tse_pkg::S_DT : tse_pkg::S_SRCH;
      end
      tse_pkg::S_SRCH: begin
        state_nxt = srch_go ? tse_pkg::S_SRCH : tse_pkg::S_DT;
      end
      tse_pkg::S_DT:    state_nxt = tse_pkg::S_SQ;
      tse_pkg::S_SQ:    state_nxt = tse_pkg::S_JLOAD;
      tse_pkg::S_JLOAD: state_nxt = tse_pkg::S_JWAIT;
      tse_pkg::S_JWAIT: begin
        if (ev_done) begin
          state_nxt = tse_pkg::S_JPUSH;
        end
      end
      tse_pkg::S_JPUSH: begin
        if (out_free) begin
          state_nxt = jlast ? tse_pkg::S_IDLE : tse_pkg::S_JLOAD;
        end
      end
      default: state_nxt = tse_pkg::S_IDLE;
    endcase
  end

  // Read addresses, evaluation start and output load
  always_comb begin
    seg_raddr  = srch_r;
    coef_raddr = CAW'(32'(seg_r) * 32'(MAX_JOINTS) + 32'(j_r));
    unique case (state_r)
      tse_pkg::S_IDLE:  seg_raddr = c0;
      tse_pkg::S_CHK_C: seg_raddr = nxt_ok ? SEGW'(CNTW'(srch_r) + CNTW'(1)) : '0;
      tse_pkg::S_CHK_N: seg_raddr = '0;
      tse_pkg::S_SRCH:  seg_raddr = SEGW'(CNTW'(srch_r) + CNTW'(1));
      tse_pkg::S_SQ:    coef_raddr = CAW'(32'(seg_r) * 32'(MAX_JOINTS));
      // Hold the current joint's entry while the output stalls
      tse_pkg::S_JPUSH: begin
        if (out_free) begin
          coef_raddr = CAW'(32'(seg_r) * 32'(MAX_JOINTS) + 32'(j_r) + 32'd1);
        end
      end
      default: ;
    endcase
    ev_start = (state_r == tse_pkg::S_JLOAD);
    out_load = ((state_r == tse_pkg::S_RESP) || (state_r == tse_pkg::S_JPUSH)) && out_free;
  end

  // Result of the current joint
  assign jlast = ((4'(j_r) + 4'd1) == n_r);
  always_comb begin
    jres.joint  = j_r;
    jres.pos    = ev.pos;
    jres.vel    = ev.vel;
    jres.acc    = cd.acc;
    jres.seg    = 6'(seg_r);
    jres.status = ev.sat ? tse_pkg::ST_SAT : tse_pkg::ST_OK;
    jres.last   = jlast;
  end

  // Single result for append, write, clear and empty evaluate
  always_comb begin
    res_nxt      = '0;
    res_nxt.last = 1'b1;
    unique case (tse_pkg::req_t'(in_req_type))
      tse_pkg::REQ_APPEND: begin
        res_nxt.seg    = full ? 6'd0 : 6'(count_r);
        res_nxt.status = full ? tse_pkg::ST_BAD : tse_pkg::ST_OK;
      end
      tse_pkg::REQ_WRITE: begin
        res_nxt.joint  = in_joint_index;
        res_nxt.seg    = in_seg_index;
        res_nxt.status = wr_bad ? tse_pkg::ST_BAD : tse_pkg::ST_OK;
      end
      tse_pkg::REQ_EVAL: begin
        res_nxt.status = (count_r == '0) ? tse_pkg::ST_EMPTY : tse_pkg::ST_OK;
      end
      tse_pkg::REQ_CLEAR: ;
      default: ;
    endcase
  end

  // dt magnitude for squaring
  assign ndt = -dt_r;
  assign adt = dt_r[32] ? ndt[31:0] : dt_r[31:0];
  assign sq  = 64'(adt) * 64'(adt);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tse_pkg::S_IDLE;
      count_r  <= '0;
      cached_r <= '0;
      cvalid_r <= 1'b0;
      jc_r     <= tse_pkg::JOINT_COUNT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        jc_r <= cfg_wdata;
      end
      if (accept) begin
        unique case (tse_pkg::req_t'(in_req_type))
          tse_pkg::REQ_APPEND: begin
            if (!full) begin
              count_r <= count_r + CNTW'(1);
            end
          end
          tse_pkg::REQ_CLEAR: begin
            count_r  <= '0;
            cached_r <= '0;
            cvalid_r <= 1'b0;
          end
          tse_pkg::REQ_EVAL: begin
            if (count_r != '0) begin
              cached_r <= c0;
              cvalid_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      // Following segment holds the time: it becomes the cached one
      if ((state_r == tse_pkg::S_CHK_N) && holds) begin
        cached_r <= srch_r;
      end
    end
  end

  // Request capture and lookup datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      qtime_r <= in_query_time;
      srch_r  <= c0;
      n_r     <= n_eff;
      res_r   <= res_nxt;
    end
    // Advance the lookup index along the addresses read
    if (((state_r == tse_pkg::S_CHK_C) || (state_r == tse_pkg::S_CHK_N) ||
         (state_r == tse_pkg::S_SRCH)) && (state_nxt != tse_pkg::S_DT)) begin
      srch_r <= seg_raddr;
    end
    // Segment chosen: hold its index and start time
    if ((state_nxt == tse_pkg::S_DT) && (state_r != tse_pkg::S_DT)) begin
      seg_r   <= srch_r;
      start_r <= sd.t_start;
    end
    if (state_r == tse_pkg::S_DT) begin
      dt_r <= $signed({1'b0, qtime_r}) - $signed({1'b0, start_r});
      j_r  <= '0;
    end
    if (state_r == tse_pkg::S_SQ) begin
      h_r <= sq[63:17];
    end
    if ((state_r == tse_pkg::S_JPUSH) && out_free) begin
      j_r <= j_r + 3'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= (state_r == tse_pkg::S_RESP) ? res_r : jres;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_joint_out    = out_r.joint;
  assign out_position     = out_r.pos;
  assign out_velocity     = out_r.vel;
  assign out_acceleration = out_r.acc;
  assign out_segment_used = out_r.seg;
  assign out_status       = out_r.status;
  assign out_last         = out_r.last;

  tse_seg_mem #(
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_mem (
    .clk   (clk),
    .we    (seg_we),
    .waddr (SEGW'(count_r)),
    .wdata ({in_start_time, in_end_time}),
    .raddr (seg_raddr),
    .rdata (sd)
  );

  tse_coef_mem #(
    .DEPTH (CDEPTH)
  ) u_coef_mem (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata ({in_start_pos, in_start_vel, in_accel_in}),
    .raddr (coef_raddr),
    .rdata (cd)
  );

  tse_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ev_start),
    .dt    (dt_r),
    .h     (h_r),
    .coef  (cd),
    .done  (ev_done),
    .res   (ev)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_SEGMENTS))
    else $error("segment count beyond table size");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ev_done |-> (state_r == tse_pkg::S_JWAIT))
    else $error("evaluation finished outside its wait state");

  a_search_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tse_pkg::S_SRCH) |-> (CNTW'(srch_r) < count_r))
    else $error("search index past last segment");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == tse_pkg::S_JPUSH) && out_load && jlast) |=> (state_r == tse_pkg::S_IDLE))
    else $error("final joint result did not end the request");
`endif

endmodule

`default_nettype wire
